@@ src/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

   localparam int unsigned CMD_BITS = 2;
   localparam int unsigned USER_BITS = 4;
   localparam int unsigned LEN_BITS = 16;
   localparam int unsigned CNT_BITS = 5;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE = 2'd1;
   localparam logic [1:0] CMD_DEFRAG = 2'd2;
   localparam logic [1:0] CMD_NOP = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_NOROOM = 2'd2;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_MOVE = 1'b1;

   localparam logic CSR_POOL_SIZE = 1'b0;
   localparam logic CSR_ACTIVE_USERS = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  user;
      logic [15:0] request_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        record_kind;
      logic [3:0]  user_index;
      logic [15:0] block_offset;
      logic [15:0] source_offset;
      logic [15:0] block_length;
      logic [4:0]  moved_count;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FIRST,
      S_FIRST_CHECK,
      S_NEXT,
      S_GAP_CHECK,
      S_DF_FIRST,
      S_DF_STEP,
      S_DF_NEXT,
      S_EMIT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic scan_step;
      logic snap_orig;
      logic keep_shrink;
      logic release_user;
      logic grant_front;
      logic grant_end;
      logic df_apply;
      logic df_cursor;
      logic out_answer;
      logic out_range;
      logic out_noroom;
      logic out_free;
      logic out_count;
   } ctl_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_alloc;
      logic is_free;
      logic is_defrag;
      logic in_range;
      logic held_fits;
      logic user_held;
      logic scan_done;
      logic found;
      logic front_fits;
      logic gap_fits;
      logic tail_fits;
      logic df_moves;
   } sts_type;

endpackage
`default_nettype wire

@@ src/ffba_datapath.sv @@
`default_nettype none
module ffba_datapath #(
   parameter int unsigned NUM_USERS = 16,
   parameter int unsigned OFFSET_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_data,
   input  wire ffba_pkg::req_type req_in,
   input  wire ffba_pkg::ctl_type ctl,
   output ffba_pkg::sts_type      sts,
   output ffba_pkg::rsp_type      rsp_data
);

   localparam int unsigned UB = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
   localparam int unsigned SB = $clog2(NUM_USERS + 1);
   localparam int unsigned EB = OFFSET_BITS + 1;

   logic [NUM_USERS-1:0]   held_ff;
   logic [OFFSET_BITS-1:0] start_ff [NUM_USERS];
   logic [OFFSET_BITS-1:0] size_ff [NUM_USERS];
   logic [OFFSET_BITS-1:0] orig_ff [NUM_USERS];
   logic [15:0]            pool_ff;
   logic [4:0]             active_ff;
   ffba_pkg::req_type      req_ff;
   logic [UB-1:0]          user_ff;

   // Scan over descriptors: one descriptor per cycle.
   logic [SB-1:0]          idx_ff;
   logic                   scanning_ff;
   logic                   have_key_ff;
   logic [OFFSET_BITS-1:0] key_off_ff;
   logic [UB-1:0]          key_idx_ff;
   logic                   best_ok_ff;
   logic [OFFSET_BITS-1:0] best_off_ff;
   logic [UB-1:0]          best_idx_ff;
   logic                   use_orig_ff;

   logic [EB-1:0]                   end_ff;
   logic [EB-1:0]                   cursor_ff;
   logic [ffba_pkg::CNT_BITS-1:0]   moved_ff;
   ffba_pkg::rsp_type               out_ff;
   ffba_pkg::rsp_type               out_in;

   logic [SB-1:0]          seen;
   logic [UB-1:0]          idx_u;
   logic [OFFSET_BITS-1:0] cand_off;
   logic                   cand_ok;
   logic [OFFSET_BITS-1:0] req_len;
   logic [EB-1:0]          best_start;

   assign seen = (32'(active_ff) < NUM_USERS) ? SB'(active_ff) : SB'(NUM_USERS);
   assign idx_u = idx_ff[UB-1:0];
   assign cand_off = use_orig_ff ? orig_ff[idx_u] : start_ff[idx_u];
   assign cand_ok = held_ff[idx_u] &&
                    (!have_key_ff || cand_off > key_off_ff ||
                     (cand_off == key_off_ff && idx_u > key_idx_ff)) &&
                    (!best_ok_ff || cand_off < best_off_ff);
   assign req_len = OFFSET_BITS'(req_ff.request_length);
   assign best_start = EB'(best_off_ff);

   always_comb begin
      sts.is_alloc = (req_ff.cmd == ffba_pkg::CMD_ALLOC);
      sts.is_free = (req_ff.cmd == ffba_pkg::CMD_FREE);
      sts.is_defrag = (req_ff.cmd == ffba_pkg::CMD_DEFRAG);
      sts.in_range = SB'(req_ff.user) < seen && 32'(req_ff.user) < NUM_USERS;
      sts.user_held = held_ff[user_ff];
      sts.held_fits = size_ff[user_ff] >= req_len;
      sts.scan_done = !scanning_ff;
      sts.found = best_ok_ff;
      sts.front_fits = best_off_ff >= req_len;
      sts.gap_fits = best_start >= end_ff && (best_start - end_ff) >= EB'(req_len);
      sts.tail_fits = (end_ff + EB'(req_len)) <= EB'(pool_ff);
      sts.df_moves = EB'(start_ff[best_idx_ff]) > cursor_ff;
   end

   always_comb begin
      out_in = '0;
      out_in.last = !ctl.df_apply;
      out_in.user_index = req_ff.user;
      if (ctl.out_range) out_in.status = ffba_pkg::ST_RANGE;
      if (ctl.out_noroom) out_in.status = ffba_pkg::ST_NOROOM;
      if (ctl.out_answer) begin
         out_in.block_offset = 16'(ctl.keep_shrink ? start_ff[user_ff] :
                                   (ctl.grant_end ? end_ff[OFFSET_BITS-1:0] : '0));
         out_in.block_length = req_ff.request_length;
      end
      if (ctl.out_count) begin
         out_in.user_index = '0;
         out_in.moved_count = moved_ff;
      end
      if (ctl.df_apply) begin
         out_in.record_kind = ffba_pkg::KIND_MOVE;
         out_in.user_index = 4'(best_idx_ff);
         out_in.block_offset = 16'(cursor_ff);
         out_in.source_offset = 16'(start_ff[best_idx_ff]);
         out_in.block_length = 16'(size_ff[best_idx_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pool_ff <= '0;
         active_ff <= '0;
         scanning_ff <= 1'b0;
         moved_ff <= '0;
         for (int i = 0; i < NUM_USERS; i++) begin
            start_ff[i] <= '0;
            size_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index == ffba_pkg::CSR_POOL_SIZE) pool_ff <= csr_data;
            else active_ff <= csr_data[4:0];
         end
         if (ctl.load_req) begin
            req_ff <= req_in;
            user_ff <= UB'(req_in.user);
            moved_ff <= '0;
            cursor_ff <= '0;
            // With no block found the tail check measures from offset zero.
            end_ff <= '0;
         end
         if (ctl.snap_orig) begin
            for (int i = 0; i < NUM_USERS; i++) orig_ff[i] <= start_ff[i];
         end
         if (ctl.scan_start || ctl.scan_step) begin
            idx_ff <= '0;
            scanning_ff <= (seen != '0);
            best_ok_ff <= 1'b0;
            best_off_ff <= '0;
            use_orig_ff <= ctl.snap_orig || (use_orig_ff && ctl.scan_step);
            have_key_ff <= ctl.scan_step;
            if (ctl.scan_step) begin
               key_off_ff <= use_orig_ff ? orig_ff[best_idx_ff] : best_off_ff;
               key_idx_ff <= best_idx_ff;
            end else begin
               key_off_ff <= '0;
               key_idx_ff <= '0;
            end
         end else if (scanning_ff) begin
            if (cand_ok) begin
               best_ok_ff <= 1'b1;
               best_off_ff <= cand_off;
               best_idx_ff <= idx_u;
            end
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= seen) scanning_ff <= 1'b0;
         end
         if (ctl.release_user) begin
            held_ff[user_ff] <= 1'b0;
            start_ff[user_ff] <= '0;
            size_ff[user_ff] <= '0;
         end
         if (ctl.keep_shrink) size_ff[user_ff] <= req_len;
         if (ctl.grant_front || ctl.grant_end) begin
            held_ff[user_ff] <= 1'b1;
            start_ff[user_ff] <= ctl.grant_end ? end_ff[OFFSET_BITS-1:0] : '0;
            size_ff[user_ff] <= req_len;
         end
         // end_ff tracks the end of the block just found in the gap walk.
         if (ctl.df_cursor) begin
            end_ff <= EB'(start_ff[best_idx_ff]) + EB'(size_ff[best_idx_ff]);
         end
         if (ctl.df_apply) begin
            start_ff[best_idx_ff] <= cursor_ff[OFFSET_BITS-1:0];
            moved_ff <= moved_ff + 1'b1;
            cursor_ff <= cursor_ff + EB'(size_ff[best_idx_ff]);
         end else if (ctl.df_cursor && sts.is_defrag) begin
            cursor_ff <= EB'(start_ff[best_idx_ff]) + EB'(size_ff[best_idx_ff]);
         end
         if (ctl.out_answer || ctl.out_range || ctl.out_noroom || ctl.out_free ||
             ctl.out_count || ctl.df_apply) begin
            out_ff <= out_in;
         end
      end
   end

   assign rsp_data = out_ff;

endmodule
`default_nettype wire

@@ src/ffba_ctrl.sv @@
`default_nettype none
module ffba_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ffba_pkg::sts_type sts,
   output ffba_pkg::ctl_type      ctl
);

   ffba_pkg::state_type state_ff, state_in;
   logic                vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff && !rsp_ready;
      ctl = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in = ffba_pkg::S_DECODE;
            end
         end
         ffba_pkg::S_DECODE: begin
            if (sts.is_defrag) begin
               ctl.scan_start = 1'b1;
               ctl.snap_orig = 1'b1;
               state_in = ffba_pkg::S_DF_FIRST;
            end else if (!sts.is_alloc && !sts.is_free) begin
               state_in = ffba_pkg::S_IDLE;
            end else if (!vld_ff) begin
               if (!sts.in_range) begin
                  ctl.out_range = 1'b1;
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_IDLE;
               end else if (sts.is_free) begin
                  ctl.release_user = 1'b1;
                  ctl.out_free = 1'b1;
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_IDLE;
               end else if (sts.user_held && sts.held_fits) begin
                  ctl.keep_shrink = 1'b1;
                  ctl.out_answer = 1'b1;
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_IDLE;
               end else begin
                  ctl.release_user = sts.user_held;
                  state_in = ffba_pkg::S_FIRST;
               end
            end
         end
         ffba_pkg::S_FIRST: begin
            ctl.scan_start = 1'b1;
            state_in = ffba_pkg::S_FIRST_CHECK;
         end
         ffba_pkg::S_FIRST_CHECK: begin
            if (sts.scan_done) begin
               if (!sts.found || sts.front_fits) begin
                  // Empty pool compares against the pool size instead.
                  if (sts.found || sts.tail_fits) begin
                     ctl.grant_front = 1'b1;
                     ctl.out_answer = 1'b1;
                  end else begin
                     ctl.out_noroom = 1'b1;
                  end
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_IDLE;
               end else begin
                  ctl.df_cursor = 1'b1;
                  state_in = ffba_pkg::S_NEXT;
               end
            end
         end
         ffba_pkg::S_NEXT: begin
            ctl.scan_step = 1'b1;
            state_in = ffba_pkg::S_GAP_CHECK;
         end
         ffba_pkg::S_GAP_CHECK: begin
            if (sts.scan_done) begin
               if (sts.found && !sts.gap_fits) begin
                  ctl.df_cursor = 1'b1;
                  state_in = ffba_pkg::S_NEXT;
               end else begin
                  if (sts.found || sts.tail_fits) begin
                     ctl.grant_end = 1'b1;
                     ctl.out_answer = 1'b1;
                  end else begin
                     ctl.out_noroom = 1'b1;
                  end
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_IDLE;
               end
            end
         end
         ffba_pkg::S_DF_FIRST: begin
            if (sts.scan_done) state_in = ffba_pkg::S_DF_STEP;
         end
         ffba_pkg::S_DF_STEP: begin
            if (!sts.found) begin
               state_in = ffba_pkg::S_EMIT;
            end else if (sts.df_moves) begin
               if (!vld_ff) begin
                  ctl.df_apply = 1'b1;
                  vld_in = 1'b1;
                  state_in = ffba_pkg::S_DF_NEXT;
               end
            end else begin
               ctl.df_cursor = 1'b1;
               state_in = ffba_pkg::S_DF_NEXT;
            end
         end
         ffba_pkg::S_DF_NEXT: begin
            ctl.scan_step = 1'b1;
            state_in = ffba_pkg::S_DF_FIRST;
         end
         ffba_pkg::S_EMIT: begin
            if (!vld_ff) begin
               ctl.out_count = 1'b1;
               vld_in = 1'b1;
               state_in = ffba_pkg::S_IDLE;
            end
         end
         default: state_in = ffba_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ src/first_fit_block_allocator_core.sv @@
`default_nettype none
// First-fit block allocator: one descriptor per user over a linear pool.
// Transactions are handled one at a time. A free, an out-of-range user or a
// fitting allocate gives its result from the decode state once the previous
// result has been taken; an allocate that searches visits the held blocks in
// offset order, and each next-block search scans every active descriptor once.
// Defragment takes one scan per held block plus one final scan and the count
// record; a move record waits only while the previous result is not taken.
// Results are held in an output register until taken.
module first_fit_block_allocator_core #(
   parameter int unsigned NUM_USERS = 16,
   parameter int unsigned OFFSET_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffba_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffba_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_data
);

   ffba_pkg::ctl_type ctl;
   ffba_pkg::sts_type sts;

   ffba_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .ctl(ctl)
   );

   ffba_datapath #(.NUM_USERS(NUM_USERS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_in(req_data), .ctl(ctl), .sts(sts), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

@@ src/ffba_checker.sv @@
`default_nettype none
module ffba_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ffba_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_move_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == ffba_pkg::KIND_MOVE |-> !rsp_data.last)
      else $error("move record marked last");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("input taken during multi-record result");

endmodule

bind first_fit_block_allocator_core ffba_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

@@ dv/tb_first_fit_block_allocator_core.sv @@
`default_nettype none
module tb_first_fit_block_allocator_core;

   localparam int NUSR = 16;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ffba_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ffba_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   first_fit_block_allocator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Allocator state as the testbench believes it to be.
   logic        mdl_held [NUSR];
   logic [15:0] mdl_start [NUSR];
   logic [15:0] mdl_size [NUSR];
   logic [15:0] mdl_pool;
   logic [4:0]  mdl_active;

   ffba_pkg::rsp_type expected_records[$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input ffba_pkg::rsp_type got,
                                  input ffba_pkg::rsp_type exp);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   function automatic int users_seen();
      return (mdl_active < NUSR) ? int'(mdl_active) : NUSR;
   endfunction

   // Next held block after (ps, pi) in (offset, user) order, -1 if none.
   function automatic int next_block(input logic [15:0] st [NUSR], input bit have,
                                     input logic [15:0] ps, input int pi);
      int best;
      logic [15:0] bs;
      best = -1;
      bs = '0;
      for (int n = 0; n < users_seen(); n++) begin
         if (!mdl_held[n]) continue;
         if (have && !(st[n] > ps || (st[n] == ps && n > pi))) continue;
         if (best < 0 || st[n] < bs) begin
            best = n;
            bs = st[n];
         end
      end
      return best;
   endfunction

   function automatic ffba_pkg::rsp_type mk(input logic [1:0] s, input logic k, input int u,
                                            input logic [15:0] off, input logic [15:0] src,
                                            input logic [15:0] len, input logic [4:0] mv,
                                            input logic lst);
      ffba_pkg::rsp_type r;
      r.status = s; r.record_kind = k; r.user_index = u[3:0];
      r.block_offset = off; r.source_offset = src; r.block_length = len;
      r.moved_count = mv; r.last = lst;
      return r;
   endfunction

   task automatic predict_allocate(input int u, input logic [15:0] len);
      bit ok;
      int at, cur, nx, endp;
      ok = 0;
      at = 0;
      if (mdl_held[u]) begin
         if (mdl_size[u] >= len) begin
            mdl_size[u] = len;
            expected_records.push_back(mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, u,
                                          mdl_start[u], 0, len, 0, 1));
            return;
         end
         mdl_held[u] = 0; mdl_start[u] = 0; mdl_size[u] = 0;
      end
      cur = next_block(mdl_start, 0, 0, 0);
      if (cur < 0) begin
         if (len <= mdl_pool) ok = 1;
      end else if (mdl_start[cur] >= len) begin
         ok = 1;
      end else begin
         while (cur >= 0) begin
            endp = int'(mdl_start[cur]) + int'(mdl_size[cur]);
            nx = next_block(mdl_start, 1, mdl_start[cur], cur);
            if (nx >= 0) begin
               if (int'(mdl_start[nx]) >= endp && int'(mdl_start[nx]) - endp >= int'(len)) begin
                  ok = 1; at = endp;
                  break;
               end
               cur = nx;
            end else begin
               if (endp + int'(len) <= int'(mdl_pool)) begin
                  ok = 1; at = endp;
               end
               break;
            end
         end
      end
      if (!ok) begin
         expected_records.push_back(mk(ffba_pkg::ST_NOROOM, ffba_pkg::KIND_ANSWER, u,
                                       0, 0, 0, 0, 1));
         return;
      end
      mdl_held[u] = 1;
      mdl_start[u] = at[15:0];
      mdl_size[u] = len;
      expected_records.push_back(mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, u,
                                    mdl_start[u], 0, len, 0, 1));
   endtask

   task automatic predict_compaction();
      logic [15:0] orig [NUSR];
      int cursor, cur;
      logic [4:0] moved;
      orig = mdl_start;
      cursor = 0;
      moved = 0;
      cur = next_block(orig, 0, 0, 0);
      while (cur >= 0) begin
         if (int'(mdl_start[cur]) > cursor) begin
            expected_records.push_back(mk(ffba_pkg::ST_OK, ffba_pkg::KIND_MOVE, cur,
                                          cursor[15:0], mdl_start[cur],
                                          mdl_size[cur], 0, 0));
            mdl_start[cur] = cursor[15:0];
            moved++;
         end
         cursor = int'(mdl_start[cur]) + int'(mdl_size[cur]);
         cur = next_block(orig, 1, orig[cur], cur);
      end
      expected_records.push_back(mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, 0,
                                    0, 0, 0, moved, 1));
   endtask

   task automatic predict(input ffba_pkg::req_type t);
      if (t.cmd == ffba_pkg::CMD_DEFRAG) predict_compaction();
      else if (t.cmd == ffba_pkg::CMD_NOP) return;
      else if (int'(t.user) >= users_seen())
         expected_records.push_back(mk(ffba_pkg::ST_RANGE, ffba_pkg::KIND_ANSWER, t.user,
                                       0, 0, 0, 0, 1));
      else if (t.cmd == ffba_pkg::CMD_ALLOC) predict_allocate(t.user, t.request_length);
      else begin
         mdl_held[t.user] = 0; mdl_start[t.user] = 0; mdl_size[t.user] = 0;
         expected_records.push_back(mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, t.user,
                                       0, 0, 0, 0, 1));
      end
   endtask

   // Result side: random stall, compare each accepted transaction.
   always @(posedge clock) begin
      ffba_pkg::rsp_type exp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               report_mismatch("unexpected record", rsp_data, '0);
            end else begin
               exp = expected_records.pop_front();
               if (rsp_data.status != exp.status) report_mismatch("status", rsp_data, exp);
               if (rsp_data.record_kind != exp.record_kind)
                  report_mismatch("record_kind", rsp_data, exp);
               if (rsp_data.user_index != exp.user_index)
                  report_mismatch("user_index", rsp_data, exp);
               if (rsp_data.block_offset != exp.block_offset)
                  report_mismatch("block_offset", rsp_data, exp);
               if (rsp_data.source_offset != exp.source_offset)
                  report_mismatch("source_offset", rsp_data, exp);
               if (rsp_data.block_length != exp.block_length)
                  report_mismatch("block_length", rsp_data, exp);
               if (rsp_data.moved_count != exp.moved_count)
                  report_mismatch("moved_count", rsp_data, exp);
               if (rsp_data.last != exp.last) report_mismatch("last", rsp_data, exp);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == ffba_pkg::CSR_POOL_SIZE) mdl_pool = val;
      else mdl_active = val[4:0];
   endtask

   // Valid stays high from one accepted transaction straight into the next
   // unless the sender idles; apart from drain, it is lowered only while idling.
   task automatic send(input ffba_pkg::req_type t);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      predict(t);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      // A no-op transaction yields nothing; let any trailing work settle.
      repeat (400) @(posedge clock);
   endtask

   function automatic ffba_pkg::req_type mkreq(input logic [1:0] c, input int u,
                                               input int len);
      ffba_pkg::req_type t;
      t.cmd = c; t.user = u[3:0]; t.request_length = len[15:0];
      return t;
   endfunction

   typedef struct {
      ffba_pkg::req_type t;
      bit                typed;
      ffba_pkg::rsp_type r;
   } row_type;

   initial begin
      row_type rows[$];
      ffba_pkg::req_type t;
      int phase, r;
      for (int i = 0; i < NUSR; i++) begin
         mdl_held[i] = 0; mdl_start[i] = 0; mdl_size[i] = 0;
      end
      mdl_pool = 0;
      mdl_active = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with a few results typed in directly.
      write_reg(ffba_pkg::CSR_POOL_SIZE, 16'd0);
      write_reg(ffba_pkg::CSR_ACTIVE_USERS, 5'd0);
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 0, 0), 1,
                       mk(ffba_pkg::ST_RANGE, ffba_pkg::KIND_ANSWER, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mkreq(ffba_pkg::CMD_DEFRAG, 0, 0), 1,
                       mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, 0, 0, 0, 0, 0, 1)});
      rows.push_back('{mkreq(ffba_pkg::CMD_NOP, 5, 9), 0, '0});
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            t = rows[i].t;
            send(t);
            if (expected_records.size() != 0 && expected_records[$] != rows[i].r)
               report_mismatch("typed row", expected_records[$], rows[i].r);
         end else send(rows[i].t);
      end
      drain();
      rows.delete();
      write_reg(ffba_pkg::CSR_POOL_SIZE, 16'hFFFF);
      write_reg(ffba_pkg::CSR_ACTIVE_USERS, 5'd16);
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 0, 16'hFFFF), 1,
                       mk(ffba_pkg::ST_OK, ffba_pkg::KIND_ANSWER, 0, 0, 0, 16'hFFFF, 0, 1)});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 1, 1), 1,
                       mk(ffba_pkg::ST_NOROOM, ffba_pkg::KIND_ANSWER, 1, 0, 0, 0, 0, 1)});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 0, 100), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 1, 0), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 2, 50), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 15, 30), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_FREE, 0, 0), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 3, 80), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 4, 10), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 2, 200), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_FREE, 3, 0), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_DEFRAG, 0, 0), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 4, 5), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_FREE, 15, 16'hFFFF), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_DEFRAG, 15, 0), 0, '0});
      rows.push_back('{mkreq(ffba_pkg::CMD_ALLOC, 7, 16'hFF00), 0, '0});
      foreach (rows[i]) begin
         send(rows[i].t);
         if (rows[i].typed && expected_records[$] != rows[i].r)
            report_mismatch("typed row", expected_records[$], rows[i].r);
      end
      drain();
      // Shrink the user set so some blocks drop out of sight, then grow it back.
      write_reg(ffba_pkg::CSR_ACTIVE_USERS, 5'd2);
      send(mkreq(ffba_pkg::CMD_ALLOC, 1, 300));
      send(mkreq(ffba_pkg::CMD_FREE, 9, 0));
      drain();
      write_reg(ffba_pkg::CSR_ACTIVE_USERS, 5'd31);
      send(mkreq(ffba_pkg::CMD_DEFRAG, 0, 0));
      drain();

      // Random part in three idling phases.
      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 32 : (phase == 1) ? 52 : 0;
         recv_idle = (phase == 0) ? 52 : (phase == 1) ? 32 : 0;
         for (int blk = 0; blk < 3; blk++) begin
            drain();
            write_reg(ffba_pkg::CSR_POOL_SIZE, ($urandom_range(3) == 0) ? 16'($urandom) :
                                                16'($urandom_range(2000)));
            write_reg(ffba_pkg::CSR_ACTIVE_USERS,
                      5'($urandom_range(($urandom_range(4) == 0) ? 31 : 16)));
            for (int i = 0; i < 28; i++) begin
               r = $urandom_range(99);
               t.user = 4'($urandom);
               t.request_length = ($urandom_range(9) == 0) ? 16'($urandom) :
                                   16'($urandom_range(400));
               t.cmd = (r < 55) ? ffba_pkg::CMD_ALLOC : (r < 82) ? ffba_pkg::CMD_FREE :
                       (r < 96) ? ffba_pkg::CMD_DEFRAG : ffba_pkg::CMD_NOP;
               send(t);
            end
         end
      end
      drain();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
